/* hdl/affine_point_transform_defines.svh */
// assertion macros for the affine point transform block
// used by the queue module, compiled out when SYNTH is defined
`ifndef AFFINE_POINT_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTH
`define APT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apt assertion failed");
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apt assertion failed");
`else
`define APT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/apt_pkg.sv */
// shared types and constants for the affine point transform block
// no dependencies
package apt_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 4;
  localparam int NUM_ELEMS = 12;
  localparam int NUM_ROWS  = 3;
  localparam int ROW_LEN   = 4;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;

  localparam logic [WORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_XFORM = 2'd1,
    OP_IDENT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // a carries the element value for writes, x for transforms
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } entry_t;

endpackage

/* hdl/apt_front.sv */
// input side: accepts items, drops ignored ones, builds queue entries
// depends on apt_pkg
module apt_front
  import apt_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_opcode,
  input  logic [IDX_W-1:0]      in_index,
  input  logic [WORD_W-1:0]     in_value,
  input  logic [WORD_W-1:0]     in_x,
  input  logic [WORD_W-1:0]     in_y,
  input  logic [WORD_W-1:0]     in_z,
  input  logic                  q_full_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  op_t  op;
  logic keep;

  always_comb begin
    op = op_t'(in_opcode);
    case (op)
      OP_WRITE: keep = (in_index < IDX_W'(NUM_ELEMS));
      OP_XFORM: keep = 1'b1;
      OP_IDENT: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign in_tready = !q_full_i;
  assign push_o    = in_tvalid && !q_full_i && keep;

  always_comb begin
    entry_o.op  = op;
    entry_o.idx = in_index;
    entry_o.a   = (op == OP_WRITE) ? in_value : in_x;
    entry_o.b   = in_y;
    entry_o.c   = in_z;
  end

endmodule

/* hdl/apt_queue.sv */
// short fifo between front and back
// depends on apt_pkg and affine_point_transform_defines.svh
`include "affine_point_transform_defines.svh"
module apt_queue
  import apt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt  = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  `APT_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop_i, count_r != '0)
  `APT_ASSERT_SAME(a_no_push_full, clk, rst_n, push_i && !pop_i, count_r != CNT_W'(DEPTH))
  `APT_ASSERT_NEXT(a_count_up, clk, rst_n, push_i && !pop_i, count_r == CNT_W'($past(count_r) + 1'b1))

endmodule

/* hdl/apt_back.sv */
// back side: matrix storage, multiply, add, floor shift and saturate
// depends on apt_pkg
module apt_back
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  entry_t                head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int PSUM_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

  logic [WORD_W-1:0]        m_r [NUM_ELEMS];
  logic signed [PROD_W-1:0] p_r [NUM_ROWS][NUM_ROWS];
  logic signed [PROD_W-1:0] t_r [NUM_ROWS];
  logic signed [PSUM_W-1:0] sa_r [NUM_ROWS];
  logic signed [PSUM_W-1:0] sb_r [NUM_ROWS];
  logic                     v1_r, v2_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                     out_sat_r, out_sat_nxt;
  logic                     adv;
  logic                     take;

  assign adv   = !out_valid_r || out_tready;
  assign take  = adv && !empty_i;
  assign pop_o = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        m_r[i] <= '0;
      end
    end else if (take) begin
      case (head_i.op)
        OP_WRITE: begin
          m_r[head_i.idx] <= head_i.a;
        end
        OP_IDENT: begin
          for (int i = 0; i < NUM_ELEMS; i++) begin
            m_r[i] <= ((i % 5) == 0) ? ONE : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= take && (head_i.op == OP_XFORM);
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // stage 1: nine products and the translation terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        p_r[r][0] <= $signed(m_r[r*ROW_LEN])     * $signed(head_i.a);
        p_r[r][1] <= $signed(m_r[r*ROW_LEN + 1]) * $signed(head_i.b);
        p_r[r][2] <= $signed(m_r[r*ROW_LEN + 2]) * $signed(head_i.c);
        t_r[r]    <= $signed({{WORD_W{m_r[r*ROW_LEN + 3][WORD_W-1]}},
                               m_r[r*ROW_LEN + 3]}) <<< FRAC_BITS;
      end
    end
  end

  // stage 2: partial sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sa_r[r] <= PSUM_W'(p_r[r][0]) + PSUM_W'(p_r[r][1]);
        sb_r[r] <= PSUM_W'(p_r[r][2]) + PSUM_W'(t_r[r]);
      end
    end
  end

  // stage 3: final sum, floor shift, saturate
  always_comb begin
    logic signed [SUM_W-1:0]  s;
    logic signed [SUM_W-1:0]  q;
    logic [SUM_W-WORD_W:0]    hi;
    logic                     ok;
    out_data_nxt = '0;
    out_sat_nxt  = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      s  = SUM_W'(sa_r[r]) + SUM_W'(sb_r[r]);
      q  = s >>> FRAC_BITS;
      hi = q[SUM_W-1:WORD_W-1];
      ok = (&hi) || !(|hi);
      if (ok) begin
        out_data_nxt[r*WORD_W +: WORD_W] = q[WORD_W-1:0];
      end else begin
        out_data_nxt[r*WORD_W +: WORD_W] = q[SUM_W-1] ? SAT_MIN : SAT_MAX;
        out_sat_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

/* hdl/affine_point_transform.sv */
// a point passes the queue, the stage 1 and 2 registers, then the output register
// one item per cycle unless stalled, set by nine parallel multipliers and one queue read
// writes, identity loads and ignored items produce no result transfer
// reset: synchronous active-low rst_n clears the matrix to zero and empties the queue
// top level, depends on apt_pkg, apt_front, apt_queue, apt_back
module affine_point_transform
  import apt_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // element_index, element_value, point_x, point_y, point_z, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_x, out_y, out_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // saturated
  output logic                  out_tuser
);

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  entry_t entry;
  entry_t head;

  apt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser),
    .in_index  (in_tdata[3:0]),
    .in_value  (in_tdata[35:4]),
    .in_x      (in_tdata[67:36]),
    .in_y      (in_tdata[99:68]),
    .in_z      (in_tdata[131:100]),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (entry)
  );

  apt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  apt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* sim/apt_point_checker.sv */
`timescale 1ns / 100ps
// checker for the affine point transform: tracks matrix writes seen on the input
// channel, predicts each transformed point and compares it on the result channel
// depends on apt_pkg
module apt_point_checker
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    pending,
  output int                    fail_cnt
);

  typedef struct {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              sat;
  } point_res_t;

  logic [WORD_W-1:0] mat [NUM_ELEMS];
  point_res_t        expected_points [$];
  int                fails;

  // floor of the exact row sum, then clip to signed 32 bits; bit 32 flags clipping
  function automatic logic [WORD_W:0] project_row(int r, logic [WORD_W-1:0] px,
                                                  logic [WORD_W-1:0] py,
                                                  logic [WORD_W-1:0] pz);
    logic signed [65:0] m0, m1, m2, m3, xs, ys, zs, acc;
    m0 = $signed(mat[r*ROW_LEN]);
    m1 = $signed(mat[r*ROW_LEN+1]);
    m2 = $signed(mat[r*ROW_LEN+2]);
    m3 = $signed(mat[r*ROW_LEN+3]);
    xs = $signed(px);
    ys = $signed(py);
    zs = $signed(pz);
    acc = m0 * xs + m1 * ys + m2 * zs + (m3 <<< FRAC_BITS);
    acc = acc >>> FRAC_BITS;
    if (acc > 66'sh7fffffff) return {1'b1, SAT_MAX};
    if (acc < -66'sh80000000) return {1'b1, SAT_MIN};
    return {1'b0, acc[WORD_W-1:0]};
  endfunction

  function automatic point_res_t predict_point(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
                                               logic [WORD_W-1:0] pz);
    point_res_t        res;
    logic [WORD_W:0]   rx, ry, rz;
    rx = project_row(0, px, py, pz);
    ry = project_row(1, px, py, pz);
    rz = project_row(2, px, py, pz);
    res.x   = rx[WORD_W-1:0];
    res.y   = ry[WORD_W-1:0];
    res.z   = rz[WORD_W-1:0];
    res.sat = rx[WORD_W] | ry[WORD_W] | rz[WORD_W];
    return res;
  endfunction

  always @(posedge clk) begin
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] val, px, py, pz;
    point_res_t        exp_res;
    if (!rst_n) begin
      foreach (mat[i]) mat[i] = '0;
      expected_points.delete();
      fails = 0;
    end else begin
      // result side first: a result in this cycle belongs to an earlier point
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result transfer with no expected point");
          fails++;
        end else begin
          exp_res = expected_points.pop_front();
          if (out_tdata[31:0] !== exp_res.x) begin
            $error("out_x mismatch: expected %h, got %h", exp_res.x, out_tdata[31:0]);
            fails++;
          end
          if (out_tdata[63:32] !== exp_res.y) begin
            $error("out_y mismatch: expected %h, got %h", exp_res.y, out_tdata[63:32]);
            fails++;
          end
          if (out_tdata[95:64] !== exp_res.z) begin
            $error("out_z mismatch: expected %h, got %h", exp_res.z, out_tdata[95:64]);
            fails++;
          end
          if (out_tuser !== exp_res.sat) begin
            $error("saturated mismatch: expected %b, got %b", exp_res.sat, out_tuser);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        op  = op_t'(in_tuser);
        idx = in_tdata[3:0];
        val = in_tdata[35:4];
        px  = in_tdata[67:36];
        py  = in_tdata[99:68];
        pz  = in_tdata[131:100];
        case (op)
          OP_WRITE: begin
            if (idx < NUM_ELEMS) mat[idx] = val;
          end
          OP_IDENT: begin
            foreach (mat[i]) mat[i] = (i % 5 == 0) ? (32'd1 << FRAC_BITS) : '0;
          end
          OP_XFORM: begin
            expected_points.push_back(predict_point(px, py, pz));
          end
          default: ;
        endcase
      end
    end
    pending  <= expected_points.size();
    fail_cnt <= fails;
  end

endmodule

/* sim/tb_affine_point_transform.sv */
`timescale 1ns / 100ps
// testbench top for affine_point_transform: directed and random matrix writes,
// identity loads and point transforms with random stalls on both channels
// depends on apt_pkg, the block and apt_point_checker
module tb_affine_point_transform;
  import apt_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    pending;
  int                    fail_cnt;
  int                    hold_len;
  logic                  no_gaps;
  int                    idle_cycles;

  affine_point_transform #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  apt_point_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .pending   (pending),
    .fail_cnt  (fail_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // nothing transferred on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold_len > 0 && !held) begin
        n = hold_len;
        held = 1'b1;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return WORD_W'($urandom_range(0, 1 << 19)) - (32'd1 << 18);
      2: begin
        case ($urandom_range(0, 4))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return 32'h0001_0000;
          3: return 32'hffff_0000;
          default: return '0;
        endcase
      end
      default: return WORD_W'($urandom_range(0, 1 << 24)) - (32'd1 << 23);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val,
                           logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
                           logic [WORD_W-1:0] pz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {4'b0, pz, py, px, val, idx};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_write(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    send_item(OP_WRITE, idx, val, rand_word(), rand_word(), rand_word());
  endtask

  task automatic send_point(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
                            logic [WORD_W-1:0] pz);
    send_item(OP_XFORM, IDX_W'($urandom()), rand_word(), px, py, pz);
  endtask

  task automatic send_ctrl(op_t op);
    send_item(op, IDX_W'($urandom()), rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic drain_points();
    do @(posedge clk); while (pending != 0);
    @(negedge clk);
  endtask

  initial begin
    int r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_NONE;
    hold_len  = 0;
    no_gaps   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // matrix cleared by reset
    send_point(SAT_MAX, SAT_MIN, rand_word());
    send_ctrl(OP_IDENT);
    send_point(SAT_MAX, SAT_MIN, 32'h0001_0000);
    // translation at its extremes
    send_write(4'd3, SAT_MAX);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(SAT_MAX, 32'd0, 32'd0);
    send_write(4'd7, SAT_MIN);
    send_point(32'd0, SAT_MIN, 32'd0);
    // largest product with positive clipping
    send_write(4'd0, SAT_MIN);
    send_point(SAT_MIN, 32'd0, 32'd0);
    send_write(4'd11, SAT_MIN);
    send_point(32'd0, 32'd0, SAT_MAX);
    // out-of-range index and unused opcode change nothing
    send_write(4'd12, SAT_MAX);
    send_write(4'd15, SAT_MIN);
    send_ctrl(OP_NONE);
    send_point(rand_word(), rand_word(), rand_word());
    // floor rounding of a tiny negative product
    send_ctrl(OP_IDENT);
    send_write(4'd5, 32'hffff_8000);
    send_point(32'd1, 32'd1, 32'd1);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_write(4'd10, SAT_MAX);
    send_point(32'd0, 32'd0, SAT_MAX);
    in_tvalid <= 1'b0;
    drain_points();

    for (int i = 0; i < 1500; i++) begin
      no_gaps = (i >= 700 && i < 800) || (i >= 1200 && i < 1300);
      if (i == 500) hold_len = HOLD_LEN;
      if (i == 1000) begin
        in_tvalid <= 1'b0;
        drain_points();
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 9) == 0) send_write(IDX_W'($urandom_range(12, 15)), rand_word());
        else send_write(IDX_W'($urandom_range(0, NUM_ELEMS - 1)), rand_word());
      end else if (r < 85) begin
        send_point(rand_word(), rand_word(), rand_word());
      end else if (r < 90) begin
        send_ctrl(OP_IDENT);
      end else begin
        send_ctrl(OP_NONE);
      end
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/apt_pkg.sv
hdl/apt_front.sv
hdl/apt_queue.sv
hdl/apt_back.sv
hdl/affine_point_transform.sv
sim/apt_point_checker.sv
sim/tb_affine_point_transform.sv
